// ===== hw/rtl/swm_pkg.sv =====
// Package for the sliding window maximum block.
// Holds the configuration register width, its reset value and the back-end state type.
// No dependencies.
package swm_pkg;

  localparam int CFG_WIDTH = 7;
  localparam logic [CFG_WIDTH-1:0] WINDOW_SIZE_RESET = 7'd1;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_FRONT_WAIT,
    ST_BACK_WAIT
  } back_state_e;

endpackage

// ===== hw/rtl/swm_intf.sv =====
// Valid/ready channel interfaces of the sliding window maximum block.
// Sample channel, result channel and configuration channel.
// Depends on swm_pkg.
interface swm_in_if #(
  parameter int SAMPLE_WIDTH = 32
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic                           first_of_stream;
  logic                           last_of_stream;

  modport source (output valid, sample, first_of_stream, last_of_stream, input ready);
  modport sink   (input valid, sample, first_of_stream, last_of_stream, output ready);
endinterface

interface swm_out_if #(
  parameter int SAMPLE_WIDTH = 32
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] window_max;
  logic                           last_window;

  modport source (output valid, window_max, last_window, input ready);
  modport sink   (input valid, window_max, last_window, output ready);
endinterface

interface swm_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [swm_pkg::CFG_WIDTH-1:0]  window_size;

  modport source (output valid, window_size, input ready);
  modport sink   (input valid, window_size, output ready);
endinterface

// ===== hw/rtl/sliding_window_maximum_top.sv =====
// Sliding window maximum, top level.
//
// Channels: in_i takes one signed sample per beat with first_of_stream and
// last_of_stream flags; out_o gives window_max and last_window; cfg_i writes
// window_size, which is always ready and should only be written while idle.
// A first_of_stream beat empties the deque and restarts the stream count.
// A result is given for each sample once window_size samples of the stream,
// clamped to 1..WINDOW_MAX, have arrived; a shorter stream gives no result.
// An accepted beat reaches its result through the queue and the result register.
// The back end appends a sample without removals when the result register is
// free; each deque entry removed from the front or the back adds a wait state,
// ST_FRONT_WAIT or ST_BACK_WAIT, for the registered read of the deque RAMs.
// A two-entry queue decouples the input from the back end.
// After reset the deque is empty, the stream count is zero and window_size
// is one. While the receiver stalls, the result register holds its beat and
// the back end appends no sample; the queue keeps taking beats until full.
module sliding_window_maximum_top #(
  parameter int WINDOW_MAX   = 64,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  swm_in_if.sink      in_i,
  swm_out_if.source   out_o,
  swm_cfg_if.sink     cfg_i
);
  import swm_pkg::*;

  logic [CFG_WIDTH-1:0] window_size_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_size_q <= WINDOW_SIZE_RESET;
    end else if (cfg_i.valid && cfg_i.ready) begin
      window_size_q <= cfg_i.window_size;
    end
  end

  swm_in_if #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) q_if ();

  swm_front #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .q_o    (q_if)
  );

  swm_back #(
    .WINDOW_MAX   (WINDOW_MAX),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .window_size_i (window_size_q),
    .q_i           (q_if),
    .out_o         (out_o)
  );
endmodule

// ===== hw/rtl/swm_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module swm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                     wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                     rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// ===== hw/rtl/swm_front.sv =====
// Front end: accepts sample beats and holds them in a two-entry queue for the back end.
// Depends on swm_intf.
module swm_front #(
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  swm_in_if.sink       in_i,
  swm_in_if.source     q_o
);
  logic signed [SAMPLE_WIDTH-1:0] sample_q [2];
  logic                           first_q  [2];
  logic                           last_q   [2];
  logic                           wr_ptr_q, wr_ptr_d;
  logic                           rd_ptr_q, rd_ptr_d;
  logic [1:0]                     fill_q, fill_d;
  logic                           push, pop;

  assign in_i.ready = (fill_q != 2'd2);
  assign push       = in_i.valid && in_i.ready;
  assign pop        = q_o.valid && q_o.ready;

  assign q_o.valid           = (fill_q != 2'd0);
  assign q_o.sample          = sample_q[rd_ptr_q];
  assign q_o.first_of_stream = first_q[rd_ptr_q];
  assign q_o.last_of_stream  = last_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q;
    if (push && !pop) begin
      fill_d = fill_q + 2'd1;
    end else if (pop && !push) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      sample_q[wr_ptr_q] <= in_i.sample;
      first_q[wr_ptr_q]  <= in_i.first_of_stream;
      last_q[wr_ptr_q]   <= in_i.last_of_stream;
    end
  end
endmodule

// ===== hw/rtl/swm_back.sv =====
// Back end: runs the monotonic deque over the queued samples and drives the result register.
// Depends on swm_pkg, swm_intf and swm_ram.
module swm_back #(
  parameter int WINDOW_MAX   = 64,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [swm_pkg::CFG_WIDTH-1:0] window_size_i,
  swm_in_if.sink                        q_i,
  swm_out_if.source                     out_o
);
  import swm_pkg::*;

  localparam int AW      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CW      = $clog2(WINDOW_MAX + 1);
  localparam int POS_MOD = 2 * WINDOW_MAX;
  localparam int PW      = $clog2(POS_MOD);
  localparam logic [PW:0]   AGE_MOD  = (PW + 1)'(POS_MOD);
  localparam logic [AW-1:0] RING_END = AW'(WINDOW_MAX - 1);
  localparam logic [PW-1:0] POS_END  = PW'(POS_MOD - 1);

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] i);
    return (i == RING_END) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] i);
    return (i == '0) ? RING_END : i - 1'b1;
  endfunction

  back_state_e state_q, state_d;

  logic [AW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CW-1:0] count_q, count_d, seen_q, seen_d;
  logic [PW-1:0] pos_q, pos_d;
  logic          out_valid_q, out_valid_d;

  logic signed [SAMPLE_WIDTH-1:0] front_val_q, front_val_d;
  logic [PW-1:0]                  front_pos_q, front_pos_d;
  logic signed [SAMPLE_WIDTH-1:0] back_val_q, back_val_d;
  logic signed [SAMPLE_WIDTH-1:0] out_max_q, out_max_d;
  logic                           out_last_q, out_last_d;

  logic [AW-1:0] head_e, tail_e;
  logic [CW-1:0] count_e, seen_e, seen_inc, k;
  logic [PW-1:0] pos_e;
  logic [PW:0]   age;
  logic          out_free, do_drop, do_pop, do_push, give_result;

  logic                           ram_we;
  logic [AW-1:0]                  ram_waddr, raddr_a, raddr_b;
  logic [SAMPLE_WIDTH+PW-1:0]     rdata_a;
  logic [SAMPLE_WIDTH-1:0]        rdata_b;

  // A first beat starts from an empty deque and zeroed counters.
  assign head_e  = q_i.first_of_stream ? '0 : head_q;
  assign tail_e  = q_i.first_of_stream ? '0 : tail_q;
  assign count_e = q_i.first_of_stream ? '0 : count_q;
  assign seen_e  = q_i.first_of_stream ? '0 : seen_q;
  assign pos_e   = q_i.first_of_stream ? '0 : pos_q;

  always_comb begin
    if (window_size_i == '0) begin
      k = CW'(1);
    end else if (32'(window_size_i) > 32'(WINDOW_MAX)) begin
      k = CW'(WINDOW_MAX);
    end else begin
      k = CW'(window_size_i);
    end
  end

  always_comb begin
    if (pos_e >= front_pos_q) begin
      age = {1'b0, pos_e} - {1'b0, front_pos_q};
    end else begin
      age = AGE_MOD + {1'b0, pos_e} - {1'b0, front_pos_q};
    end
  end

  assign seen_inc    = (32'(seen_e) < 32'(WINDOW_MAX)) ? seen_e + 1'b1 : seen_e;
  assign give_result = (32'(seen_inc) >= 32'(k));
  assign out_free    = !out_valid_q || out_o.ready;

  assign do_drop = (state_q == ST_RUN) && q_i.valid && (count_e != '0)
                   && (32'(age) >= 32'(k));
  assign do_pop  = (state_q == ST_RUN) && q_i.valid && !do_drop && (count_e != '0)
                   && (back_val_q < q_i.sample);
  assign do_push = (state_q == ST_RUN) && q_i.valid && !do_drop && !do_pop && out_free;

  assign q_i.ready = do_push;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_RUN: begin
        if (do_drop) begin
          state_d = ST_FRONT_WAIT;
        end else if (do_pop) begin
          state_d = ST_BACK_WAIT;
        end
      end
      ST_FRONT_WAIT: state_d = ST_RUN;
      ST_BACK_WAIT:  state_d = ST_RUN;
      default:       state_d = ST_RUN;
    endcase
  end

  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    seen_d      = seen_q;
    pos_d       = pos_q;
    front_val_d = front_val_q;
    front_pos_d = front_pos_q;
    back_val_d  = back_val_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_max_d   = out_max_q;
    out_last_d  = out_last_q;
    ram_we      = 1'b0;
    ram_waddr   = tail_e;
    raddr_a     = ring_next(head_e);
    raddr_b     = ring_prev(ring_prev(tail_e));
    unique case (state_q)
      ST_RUN: begin
        if (do_drop) begin
          head_d  = ring_next(head_e);
          count_d = count_e - 1'b1;
        end else if (do_pop) begin
          tail_d  = ring_prev(tail_e);
          count_d = count_e - 1'b1;
        end else if (do_push) begin
          ram_we     = 1'b1;
          head_d     = head_e;
          tail_d     = ring_next(tail_e);
          count_d    = count_e + 1'b1;
          seen_d     = seen_inc;
          pos_d      = (pos_e == POS_END) ? '0 : pos_e + 1'b1;
          back_val_d = q_i.sample;
          if (count_e == '0) begin
            front_val_d = q_i.sample;
            front_pos_d = pos_e;
          end
          if (give_result) begin
            out_valid_d = 1'b1;
            out_max_d   = (count_e == '0) ? q_i.sample : front_val_q;
            out_last_d  = q_i.last_of_stream;
          end
        end
      end
      ST_FRONT_WAIT: begin
        front_val_d = rdata_a[SAMPLE_WIDTH+PW-1:PW];
        front_pos_d = rdata_a[PW-1:0];
      end
      ST_BACK_WAIT: begin
        back_val_d = rdata_b;
      end
      default: begin
        out_valid_d = out_valid_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      seen_q      <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      seen_q      <= seen_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    front_val_q <= front_val_d;
    front_pos_q <= front_pos_d;
    back_val_q  <= back_val_d;
    out_max_q   <= out_max_d;
    out_last_q  <= out_last_d;
  end

  // Copy A serves front reloads with positions, copy B serves back reloads.
  swm_ram #(
    .WIDTH (SAMPLE_WIDTH + PW),
    .DEPTH (WINDOW_MAX)
  ) u_ram_front (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ({q_i.sample, pos_e}),
    .raddr_i (raddr_a),
    .rdata_o (rdata_a)
  );

  swm_ram #(
    .WIDTH (SAMPLE_WIDTH),
    .DEPTH (WINDOW_MAX)
  ) u_ram_back (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (q_i.sample),
    .raddr_i (raddr_b),
    .rdata_o (rdata_b)
  );

  assign out_o.valid       = out_valid_q;
  assign out_o.window_max  = out_max_q;
  assign out_o.last_window = out_last_q;

  logic [31:0] ring_sum;
  logic [31:0] ring_tail;
  assign ring_sum  = 32'(head_q) + 32'(count_q);
  assign ring_tail = (ring_sum >= 32'(WINDOW_MAX)) ? ring_sum - 32'(WINDOW_MAX) : ring_sum;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= 32'(WINDOW_MAX))
    else $error("Deque holds more entries than the ring can store.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ring_tail == 32'(tail_q))
    else $error("Deque head, tail and count disagree.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_RUN |=> state_q == ST_RUN)
    else $error("A RAM reload took more than one cycle.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_i.valid && q_i.ready |=> count_q != '0)
    else $error("Deque is empty right after a sample was appended.");
endmodule
